[sv/bfbp_pkg.sv]
// Shared types and constants for the best-fit buffer pool.
// Depends on nothing; every other file of the block imports it.
package bfbp_pkg;
   localparam int FREE_DEPTH  = 16;
   localparam int HANDLE_BITS = 16;
   localparam int SIZE_BITS   = 32;
   localparam int KB_BITS     = 22;
   localparam int KB_SHIFT    = 10;
   localparam int IDX_BITS    = $clog2(FREE_DEPTH);
   localparam int CNT_BITS    = $clog2(FREE_DEPTH + 1);
   localparam int INUSE_BITS  = 16;
   localparam int ROUND_BITS  = SIZE_BITS + 2;
   localparam logic [SIZE_BITS:0] MIN_PAGE = (SIZE_BITS + 1)'(4096);

   localparam logic CSR_PAGE_SIZE = 1'b0;
   localparam logic CSR_MIN_SIZE  = 1'b1;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [SIZE_BITS-1:0]   size;
   } entry_type;

   typedef enum logic [2:0] {
      STAT_REUSED    = 3'd0,
      STAT_CREATE    = 3'd1,
      STAT_EVICT     = 3'd2,
      STAT_RETURNED  = 3'd3,
      STAT_ZERO      = 3'd4,
      STAT_UNDERFLOW = 3'd5,
      STAT_OVERFLOW  = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_OUT1, ST_SCAN, ST_REUSE, ST_ROUND,
      ST_EV_RD, ST_EV_OUT, ST_SHIFT, ST_RET_WR, ST_CREATE
   } state_type;
endpackage

[sv/best_fit_buffer_pool.sv]
// Best-fit buffer pool: top level with the request sequencer and output register.
// Depends on bfbp_pkg, bfbp_ram and bfbp_round.
//
// Usage: a request item on the req_ channel either returns a buffer
// (req_type 1) or asks for one (req_type 0). Each request gives one or more
// result items on the rsp_ channel; rsp_last marks the final one. The sizes
// set through csr_ are to be written only while the block is idle; the block
// itself does not enforce it. One request is worked on at a time; req_ready
// is high only between requests. A return to a full list first evicts the
// oldest entry, with a compaction pass through the memory. An allocate scans
// the whole list; a reuse then compacts the entries behind the chosen one,
// one entry a cycle; a miss reads and evicts entries from the front one by
// one, then compacts and reports the new size. All reads go through the
// single read port of the memory.
// Reset empties the list, clears the in-use count and loads page_size_kb 64
// and min_size_kb 256. A result waits in the output register while the
// receiver stalls; the sequencer holds until that register frees up.
module best_fit_buffer_pool import bfbp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [SIZE_BITS-1:0]   req_required_size,
   input  logic [HANDLE_BITS-1:0] req_ret_handle,
   input  logic [SIZE_BITS-1:0]   req_ret_size,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_out_handle,
   output logic [SIZE_BITS-1:0]   rsp_out_size,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [KB_BITS-1:0]     csr_wdata
);
   state_type state_ff, state_in, nxt_ff, nxt_in;
   logic [KB_BITS-1:0] page_kb_ff, min_kb_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in, src_ff, src_in, dst_ff, dst_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in, sh_ff, sh_in;
   logic [INUSE_BITS-1:0] inuse_ff, inuse_in;
   logic type_ff, type_in;
   logic [SIZE_BITS-1:0] want_ff, want_in, rsize_ff, rsize_in;
   logic [HANDLE_BITS-1:0] rhandle_ff, rhandle_in;
   status_type code_ff, code_in;
   logic rv_ff, rv_in, found_ff, found_in;
   logic [IDX_BITS-1:0] ri_ff, ri_in, best_ff, best_in;
   logic [SIZE_BITS-1:0] bsize_ff, bsize_in;
   logic [HANDLE_BITS-1:0] bhandle_ff, bhandle_in;
   logic [ROUND_BITS-1:0] rounded_ff, rounded_in, rounded_c;
   logic [SIZE_BITS:0] freed_ff, freed_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [SIZE_BITS-1:0] rsp_size_ff, rsp_size_in;

   logic we;
   logic [IDX_BITS-1:0] waddr, raddr;
   entry_type wdata, rdata;
   logic out_free, ld;

   bfbp_ram #(.DEPTH(FREE_DEPTH)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   bfbp_round u_round (
      .clock(clock), .page_kb(page_kb_ff), .min_kb(min_kb_ff),
      .want_size(want_ff), .rounded(rounded_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_kb_ff <= KB_BITS'(64);
         min_kb_ff  <= KB_BITS'(256);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAGE_SIZE: page_kb_ff <= csr_wdata;
            CSR_MIN_SIZE:  min_kb_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         inuse_ff     <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         inuse_ff     <= inuse_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nxt_ff        <= nxt_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      idx_ff        <= idx_in;
      sh_ff         <= sh_in;
      type_ff       <= type_in;
      want_ff       <= want_in;
      rsize_ff      <= rsize_in;
      rhandle_ff    <= rhandle_in;
      code_ff       <= code_in;
      found_ff      <= found_in;
      ri_ff         <= ri_in;
      best_ff       <= best_in;
      bsize_ff      <= bsize_in;
      bhandle_ff    <= bhandle_in;
      rounded_ff    <= rounded_in;
      freed_ff      <= freed_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;  nxt_in = nxt_ff;     cnt_in = cnt_ff;
      src_in = src_ff;      dst_in = dst_ff;     idx_in = idx_ff;
      sh_in = sh_ff;        inuse_in = inuse_ff; type_in = type_ff;
      want_in = want_ff;    rsize_in = rsize_ff; rhandle_in = rhandle_ff;
      code_in = code_ff;    rv_in = 1'b0;        found_in = found_ff;
      ri_in = ri_ff;        best_in = best_ff;   bsize_in = bsize_ff;
      bhandle_in = bhandle_ff;  rounded_in = rounded_ff;  freed_in = freed_ff;
      ld = 1'b0;
      rsp_status_in = rsp_status_ff;  rsp_handle_in = rsp_handle_ff;
      rsp_size_in = rsp_size_ff;      rsp_last_in = rsp_last_ff;
      we = 1'b0;
      waddr = dst_ff[IDX_BITS-1:0];
      wdata = rdata;
      raddr = src_ff[IDX_BITS-1:0];
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in = req_type;
               want_in = req_required_size;
               rsize_in = req_ret_size;
               rhandle_in = req_ret_handle;
               if (req_type) begin
                  if (inuse_ff == '0) begin
                     code_in = STAT_UNDERFLOW;
                     state_in = ST_OUT1;
                  end else begin
                     inuse_in = inuse_ff - 1'b1;
                     if (cnt_ff == CNT_BITS'(FREE_DEPTH)) begin
                        idx_in = '0;
                        state_in = ST_EV_RD;
                     end else begin
                        state_in = ST_RET_WR;
                     end
                  end
               end else if (req_required_size == '0) begin
                  code_in = STAT_ZERO;
                  state_in = ST_OUT1;
               end else begin
                  src_in = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_OUT1: begin
            if (out_free) begin
               ld = 1'b1;
               rsp_status_in = code_ff;
               rsp_handle_in = '0;
               rsp_size_in = '0;
               rsp_last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // Reads are issued one entry ahead of the compare.
            if (src_ff < cnt_ff) begin
               src_in = src_ff + 1'b1;
               rv_in = 1'b1;
               ri_in = src_ff[IDX_BITS-1:0];
            end
            if (rv_ff && want_ff <= rdata.size && (!found_ff || rdata.size <= bsize_ff)) begin
               found_in = 1'b1;
               best_in = ri_ff;
               bsize_in = rdata.size;
               bhandle_in = rdata.handle;
            end
            if (src_ff >= cnt_ff && !rv_ff) begin
               state_in = found_ff ? ST_REUSE : ST_ROUND;
            end
         end
         ST_REUSE: begin
            if (out_free) begin
               ld = 1'b1;
               rsp_status_in = STAT_REUSED;
               rsp_handle_in = bhandle_ff;
               rsp_size_in = bsize_ff;
               rsp_last_in = 1'b1;
               inuse_in = inuse_ff + 1'b1;
               dst_in = CNT_BITS'(best_ff);
               src_in = CNT_BITS'(best_ff) + 1'b1;
               sh_in = CNT_BITS'(1);
               nxt_in = ST_IDLE;
               state_in = ST_SHIFT;
            end
         end
         ST_ROUND: begin
            rounded_in = rounded_c;
            idx_in = '0;
            freed_in = '0;
            if (rounded_c[ROUND_BITS-1:SIZE_BITS] != '0) begin
               code_in = STAT_OVERFLOW;
               state_in = ST_OUT1;
            end else if (cnt_ff != '0) begin
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_CREATE;
            end
         end
         ST_EV_RD: begin
            raddr = idx_ff[IDX_BITS-1:0];
            state_in = ST_EV_OUT;
         end
         ST_EV_OUT: begin
            raddr = idx_ff[IDX_BITS-1:0];
            if (out_free) begin
               ld = 1'b1;
               rsp_status_in = STAT_EVICT;
               rsp_handle_in = rdata.handle;
               rsp_size_in = rdata.size;
               rsp_last_in = 1'b0;
               idx_in = idx_ff + 1'b1;
               freed_in = freed_ff + (SIZE_BITS + 1)'(rdata.size);
               dst_in = '0;
               src_in = idx_in;
               sh_in = idx_in;
               if (type_ff) begin
                  nxt_in = ST_RET_WR;
                  state_in = ST_SHIFT;
               end else if (idx_in < cnt_ff &&
                            ROUND_BITS'(freed_in) < rounded_ff) begin
                  state_in = ST_EV_RD;
               end else begin
                  nxt_in = ST_CREATE;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // Copy entry src to dst; the read is issued in the cycle before its write.
            if (src_ff < cnt_ff) begin
               src_in = src_ff + 1'b1;
               rv_in = 1'b1;
            end
            if (rv_ff) begin
               we = 1'b1;
               dst_in = dst_ff + 1'b1;
            end
            if (src_ff >= cnt_ff && !rv_ff) begin
               cnt_in = cnt_ff - sh_ff;
               state_in = nxt_ff;
            end
         end
         ST_RET_WR: begin
            we = 1'b1;
            waddr = cnt_ff[IDX_BITS-1:0];
            wdata.handle = rhandle_ff;
            wdata.size = rsize_ff;
            cnt_in = cnt_ff + 1'b1;
            code_in = STAT_RETURNED;
            state_in = ST_OUT1;
         end
         ST_CREATE: begin
            if (out_free) begin
               ld = 1'b1;
               rsp_status_in = STAT_CREATE;
               rsp_handle_in = '0;
               rsp_size_in = rounded_ff[SIZE_BITS-1:0];
               rsp_last_in = 1'b1;
               inuse_in = inuse_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = ld ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_size   = rsp_size_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(FREE_DEPTH))
      else $error("free list count above depth");
   a_shift_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> sh_ff != '0)
      else $error("compaction pass without a removed entry");
   a_evict_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STAT_EVICT |-> !rsp_last_ff)
      else $error("eviction item marked as final");
   a_ret_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RET_WR |-> cnt_ff < CNT_BITS'(FREE_DEPTH))
      else $error("return written into a full list");
`endif
endmodule

[sv/bfbp_ram.sv]
// Free-list storage: one write port and one read port with registered read data.
// Depends on bfbp_pkg for the entry type.
module bfbp_ram import bfbp_pkg::*; #(
   parameter int DEPTH = FREE_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  entry_type                wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output entry_type                rdata
);
   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/bfbp_round.sv]
// Page size and rounded new-buffer size from the two size registers.
// Depends on bfbp_pkg; the page size is registered, the rounding follows it.
module bfbp_round import bfbp_pkg::*; (
   input  logic                  clock,
   input  logic [KB_BITS-1:0]    page_kb,
   input  logic [KB_BITS-1:0]    min_kb,
   input  logic [SIZE_BITS-1:0]  want_size,
   output logic [ROUND_BITS-1:0] rounded
);
   logic [SIZE_BITS:0] page_in, page_ff;
   logic [SIZE_BITS:0] raw, smear, minsz, want;
   logic [ROUND_BITS-1:0] mask;

   always_comb begin
      raw = (SIZE_BITS + 1)'({page_kb, KB_SHIFT'(0)});
      smear = raw - 1'b1;
      if (raw <= MIN_PAGE) begin
         page_in = MIN_PAGE;
      end else begin
         // Smear the bits below the top one, then add one: next power of two.
         smear = smear | (smear >> 1);
         smear = smear | (smear >> 2);
         smear = smear | (smear >> 4);
         smear = smear | (smear >> 8);
         smear = smear | (smear >> 16);
         page_in = smear + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   always_comb begin
      minsz = (SIZE_BITS + 1)'({min_kb, KB_SHIFT'(0)});
      if (minsz < page_ff) minsz = page_ff;
      want = {1'b0, want_size};
      if (want < minsz) want = minsz;
      mask = ROUND_BITS'(page_ff) - 1'b1;
      rounded = (ROUND_BITS'(want) + mask) & ~mask;
   end
endmodule

[dv/testbench.sv]
// Self-checking testbench for the best-fit buffer pool.
// Depends on bfbp_pkg and best_fit_buffer_pool; drives random and directed requests.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bfbp_pkg::*;

   typedef struct {
      logic                   kind;
      logic [SIZE_BITS-1:0]   req_size;
      logic [HANDLE_BITS-1:0] handle;
      logic [SIZE_BITS-1:0]   ret_size;
   } request_type;

   typedef struct {
      status_type             status;
      logic [HANDLE_BITS-1:0] handle;
      logic [SIZE_BITS-1:0]   size;
      logic                   last;
   } outcome_type;

   localparam int STALL_LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_ready, req_type;
   logic [SIZE_BITS-1:0] req_required_size, req_ret_size;
   logic [HANDLE_BITS-1:0] req_ret_handle;
   logic rsp_valid, rsp_ready;
   logic [2:0] rsp_status;
   logic [HANDLE_BITS-1:0] rsp_out_handle;
   logic [SIZE_BITS-1:0] rsp_out_size;
   logic rsp_last;
   logic csr_we, csr_index;
   logic [KB_BITS-1:0] csr_wdata;

   best_fit_buffer_pool dut (.*);

   request_type pending_reqs[$];
   outcome_type expected_outcomes[$];
   int errors = 0;
   int idle_pct = 26;
   int stall_cycles = 0;
   int n_sent = 0;
   int n_accepted = 0;

   // Predictor state.
   logic [SIZE_BITS-1:0]   pool_sizes[FREE_DEPTH];
   logic [HANDLE_BITS-1:0] pool_handles[FREE_DEPTH];
   int                     pool_count = 0;
   logic [INUSE_BITS-1:0]  in_use = '0;
   logic [KB_BITS-1:0]     page_kb = 22'd64;
   logic [KB_BITS-1:0]     min_kb = 22'd256;

   function automatic void push_outcome(status_type st, logic [HANDLE_BITS-1:0] h,
                                        logic [SIZE_BITS-1:0] sz, logic lst);
      outcome_type o;
      o.status = st; o.handle = h; o.size = sz; o.last = lst;
      expected_outcomes.push_back(o);
   endfunction

   function automatic void drop_entries(int idx, int cnt);
      for (int i = idx; i + cnt < pool_count; i++) begin
         pool_sizes[i] = pool_sizes[i + cnt];
         pool_handles[i] = pool_handles[i + cnt];
      end
      pool_count -= cnt;
   endfunction

   function automatic void predict_pool(request_type r);
      logic [63:0] page, minsz, want, rounded, freed;
      int best, cnt;
      page = 64'd4096; freed = 0; best = -1; cnt = 0;
      if (r.kind) begin
         if (in_use == 0) begin
            push_outcome(STAT_UNDERFLOW, '0, '0, 1'b1);
            return;
         end
         in_use--;
         if (pool_count >= FREE_DEPTH) begin
            push_outcome(STAT_EVICT, pool_handles[0], pool_sizes[0], 1'b0);
            drop_entries(0, 1);
         end
         pool_sizes[pool_count] = r.ret_size;
         pool_handles[pool_count] = r.handle;
         pool_count++;
         push_outcome(STAT_RETURNED, '0, '0, 1'b1);
         return;
      end
      if (r.req_size == 0) begin
         push_outcome(STAT_ZERO, '0, '0, 1'b1);
         return;
      end
      for (int i = 0; i < pool_count; i++)
         if (r.req_size <= pool_sizes[i] && (best < 0 || pool_sizes[i] <= pool_sizes[best]))
            best = i;
      if (best >= 0) begin
         push_outcome(STAT_REUSED, pool_handles[best], pool_sizes[best], 1'b1);
         drop_entries(best, 1);
         in_use++;
         return;
      end
      while (page < (64'(page_kb) << 10)) page <<= 1;
      minsz = 64'(min_kb) << 10;
      if (minsz < page) minsz = page;
      want = (64'(r.req_size) < minsz) ? minsz : 64'(r.req_size);
      rounded = (want + page - 1) & ~(page - 1);
      if (rounded > 64'hFFFF_FFFF) begin
         push_outcome(STAT_OVERFLOW, '0, '0, 1'b1);
         return;
      end
      while (cnt < pool_count && freed < rounded) begin
         freed += pool_sizes[cnt];
         push_outcome(STAT_EVICT, pool_handles[cnt], pool_sizes[cnt], 1'b0);
         cnt++;
      end
      drop_entries(0, cnt);
      in_use++;
      push_outcome(STAT_CREATE, '0, rounded[SIZE_BITS-1:0], 1'b1);
   endfunction

   function automatic void add_req(logic kind, logic [31:0] rs, logic [15:0] h,
                                   logic [31:0] sz);
      request_type r;
      r.kind = kind; r.req_size = rs; r.handle = h; r.ret_size = sz;
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [31:0] rand_size();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(1, 16);
         default: return $urandom_range(1, 32'h0010_0000);
      endcase
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Driver: presents the oldest pending item once the previous one is accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || n_accepted == n_sent) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_type <= pending_reqs[0].kind;
            req_required_size <= pending_reqs[0].req_size;
            req_ret_handle <= pending_reqs[0].handle;
            req_ret_size <= pending_reqs[0].ret_size;
            n_sent = n_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   // Predicts each input item at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_pool(pending_reqs.pop_front());
         n_accepted <= n_accepted + 1;
      end
   end

   // Monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("unexpected result item, status %0d", rsp_status);
            errors++;
         end else begin
            e = expected_outcomes.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_out_handle !== e.handle) begin
               $error("out_handle expected %h actual %h", e.handle, rsp_out_handle);
               errors++;
            end
            if (rsp_out_size !== e.size) begin
               $error("out_size expected %h actual %h", e.size, rsp_out_size);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %b actual %b", e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted item on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [KB_BITS-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PAGE_SIZE) page_kb = val; else min_kb = val;
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         // Returns are weighted so the list fills and overflows on return.
         if ($urandom_range(0, 99) < 55)
            add_req(1'b1, $urandom, 16'($urandom), rand_size());
         else if ($urandom_range(0, 19) == 0)
            add_req(1'b0, 32'd0, 16'($urandom), $urandom);
         else
            add_req(1'b0, rand_size(), 16'($urandom), $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_type = 1'b0; req_required_size = '0;
      req_ret_handle = '0; req_ret_size = '0; rsp_ready = 1'b0;
      csr_we = 1'b0; csr_index = CSR_PAGE_SIZE; csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: underflow, zero request, creates, returns, extremes, full list.
      add_req(1'b1, 32'd0, 16'hFFFF, 32'd5);
      add_req(1'b0, 32'd0, 16'd0, 32'd0);
      add_req(1'b0, 32'd1, 16'd0, 32'd0);
      add_req(1'b0, 32'hFFFF_FFFF, 16'd0, 32'd0);
      add_req(1'b0, 32'h8000_0000, 16'd0, 32'd0);
      add_req(1'b1, 32'd0, 16'hFFFF, 32'hFFFF_FFFF);
      add_req(1'b1, 32'd0, 16'h0000, 32'd0);
      add_req(1'b0, 32'hFFFF_FFFF, 16'd0, 32'd0);
      for (int i = 0; i < 18; i++) add_req(1'b0, 32'd100, 16'd0, 32'd0);
      for (int i = 0; i < 17; i++) add_req(1'b1, 32'd0, 16'(i), 32'(i * 1000));
      drain();

      idle_pct = 0;
      random_phase(60);
      drain();
      idle_pct = 26;
      write_csr(CSR_PAGE_SIZE, 22'h3F_FFFF);
      write_csr(CSR_MIN_SIZE, 22'd0);
      random_phase(90);
      drain();
      write_csr(CSR_PAGE_SIZE, 22'd0);
      write_csr(CSR_MIN_SIZE, 22'h3F_FFFF);
      random_phase(90);
      drain();
      write_csr(CSR_PAGE_SIZE, 22'd3);
      write_csr(CSR_MIN_SIZE, 22'd1);
      random_phase(100);
      drain();
      write_csr(CSR_PAGE_SIZE, 22'($urandom));
      write_csr(CSR_MIN_SIZE, 22'($urandom_range(0, 4096)));
      random_phase(50);
      drain();

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

[best_fit_buffer_pool.f]
sv/bfbp_pkg.sv
sv/bfbp_ram.sv
sv/bfbp_round.sv
sv/best_fit_buffer_pool.sv
dv/testbench.sv
